// ----- rtl/core/acmf_pkg.sv -----
package acmf_pkg;

  localparam int unsigned ACMF_ENTRIES = 16;

  localparam int unsigned IP_W  = 32;
  localparam int unsigned MAC_W = 48;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_ZERO     = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_SKIPPED  = 3'd4,
    ST_INSERTED = 3'd5,
    ST_REPLACED = 3'd6
  } status_e;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_PUT    = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ORD,
    S_IP,
    S_CMP,
    S_MISS,
    S_REPL,
    S_SHRD,
    S_SHWR,
    S_FRONT,
    S_DONE
  } state_e;

endpackage

// ----- rtl/core/acmf_req_if.sv -----
interface acmf_req_if
  import acmf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [IP_W-1:0]    ip_addr;
  logic [MAC_W-1:0]   mac_in;
  logic               insert_allowed;

  modport source (output valid, output cmd, output ip_addr, output mac_in,
                  output insert_allowed, input ready);
  modport sink   (input valid, input cmd, input ip_addr, input mac_in,
                  input insert_allowed, output ready);
endinterface

// ----- rtl/core/acmf_rsp_if.sv -----
interface acmf_rsp_if
  import acmf_pkg::*;
();
  logic               valid;
  logic               ready;
  status_e            status;
  logic [MAC_W-1:0]   mac_out;

  modport source (output valid, output status, output mac_out, input ready);
  modport sink   (input valid, input status, input mac_out, output ready);
endinterface

// ----- rtl/core/arp_cache_move_to_front_unit.sv -----
// ARP address cache of ENTRIES IPv4/MAC pairs kept in recency order. One request word
// is taken at a time and gives one response word. Pairs, and the position-to-entry
// order, sit in single-port-read synchronous memories, so the search walks the used
// positions front to back with an order read, an address read and a compare for each.
// A lookup hit then moves the entry to the front: each position passed is read and
// written one place back, then the entry is written at the front; an insert into a
// free entry shifts all used positions the same way. A put of IP zero skips the
// search, and a response still waiting holds a finished request until it is taken.
// The next request is taken while a finished response waits.
// Reset empties the cache at once; no clearing pass is run.
module arp_cache_move_to_front_unit
  import acmf_pkg::*;
#(
  parameter int unsigned ENTRIES = ACMF_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  acmf_req_if.sink    req_i,
  acmf_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic [IP_W-1:0]  ip_mem  [ENTRIES];
  logic [MAC_W-1:0] mac_mem [ENTRIES];
  logic [IdxW-1:0]  ord_mem [ENTRIES];

  state_e            state_q, state_d;
  logic [CntW-1:0]   used_q, used_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic [IdxW-1:0]   k_q, k_d;
  logic [IdxW-1:0]   slot_q, slot_d;
  logic              cmd_q, cmd_d;
  logic [IP_W-1:0]   ip_q, ip_d;
  logic [MAC_W-1:0]  mac_q, mac_d;
  logic              ins_q, ins_d;
  status_e           st_q, st_d;
  logic [MAC_W-1:0]  res_mac_q, res_mac_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_st_q, out_st_d;
  logic [MAC_W-1:0]  out_mac_q, out_mac_d;

  logic              ent_we, ip_we_en;
  logic [IdxW-1:0]   ent_waddr;
  logic              mac_we;
  logic              ord_we;
  logic [IdxW-1:0]   ord_waddr, ord_wdata;
  logic              ord_re, ent_re;
  logic [IdxW-1:0]   ord_raddr, ent_raddr;
  logic [IdxW-1:0]   ord_rdata_q;
  logic [IP_W-1:0]   ip_rdata_q;
  logic [MAC_W-1:0]  mac_rdata_q;

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = out_st_q;
  assign rsp_o.mac_out = out_mac_q;

  always_ff @(posedge clk_i) begin
    if (ip_we_en) begin
      ip_mem[ent_waddr] <= ip_q;
    end
    if (mac_we) begin
      mac_mem[ent_waddr] <= mac_q;
    end
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_rdata_q <= ord_mem[ord_raddr];
    end
    if (ent_re) begin
      ip_rdata_q  <= ip_mem[ent_raddr];
      mac_rdata_q <= mac_mem[ent_raddr];
    end
  end

  assign ip_we_en = ent_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    k_q       <= k_d;
    slot_q    <= slot_d;
    cmd_q     <= cmd_d;
    ip_q      <= ip_d;
    mac_q     <= mac_d;
    ins_q     <= ins_d;
    st_q      <= st_d;
    res_mac_q <= res_mac_d;
    out_st_q  <= out_st_d;
    out_mac_q <= out_mac_d;
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    pos_d       = pos_q;
    k_d         = k_q;
    slot_d      = slot_q;
    cmd_d       = cmd_q;
    ip_d        = ip_q;
    mac_d       = mac_q;
    ins_d       = ins_q;
    st_d        = st_q;
    res_mac_d   = res_mac_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_mac_d   = out_mac_q;
    ent_we      = 1'b0;
    mac_we      = 1'b0;
    ent_waddr   = slot_q;
    ord_we      = 1'b0;
    ord_waddr   = k_q;
    ord_wdata   = ord_rdata_q;
    ord_re      = 1'b0;
    ord_raddr   = pos_q;
    ent_re      = 1'b0;
    ent_raddr   = ord_rdata_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_d     = req_i.cmd;
          ip_d      = req_i.ip_addr;
          mac_d     = req_i.mac_in;
          ins_d     = req_i.insert_allowed;
          res_mac_d = '0;
          pos_d     = '0;
          if (req_i.cmd == CMD_PUT && req_i.ip_addr == '0) begin
            st_d    = ST_ZERO;
            state_d = S_DONE;
          end else if (used_q == '0) begin
            state_d = S_MISS;
          end else begin
            state_d = S_ORD;
          end
        end
      end
      S_ORD: begin
        ord_re    = 1'b1;
        ord_raddr = pos_q;
        state_d   = S_IP;
      end
      S_IP: begin
        slot_d    = ord_rdata_q;
        ent_re    = 1'b1;
        ent_raddr = ord_rdata_q;
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (ip_rdata_q == ip_q) begin
          if (cmd_q == CMD_LOOKUP) begin
            res_mac_d = mac_rdata_q;
            st_d      = ST_HIT;
            k_d       = pos_q;
            state_d   = (pos_q == '0) ? S_FRONT : S_SHRD;
          end else begin
            mac_we    = 1'b1;
            ent_waddr = slot_q;
            st_d      = ST_UPDATED;
            state_d   = S_DONE;
          end
        end else if ((CntW'(pos_q) + CntW'(1)) == used_q) begin
          state_d = S_MISS;
        end else begin
          pos_d   = pos_q + IdxW'(1);
          state_d = S_ORD;
        end
      end
      S_MISS: begin
        if (cmd_q == CMD_LOOKUP) begin
          st_d    = ST_MISS;
          state_d = S_DONE;
        end else if (!ins_q) begin
          st_d    = ST_SKIPPED;
          state_d = S_DONE;
        end else if (used_q < CntW'(ENTRIES)) begin
          ent_we    = 1'b1;
          mac_we    = 1'b1;
          ent_waddr = used_q[IdxW-1:0];
          slot_d    = used_q[IdxW-1:0];
          k_d       = used_q[IdxW-1:0];
          used_d    = used_q + CntW'(1);
          st_d      = ST_INSERTED;
          state_d   = (used_q == '0) ? S_FRONT : S_SHRD;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = IdxW'(ENTRIES - 1);
          state_d   = S_REPL;
        end
      end
      S_REPL: begin
        ent_we    = 1'b1;
        mac_we    = 1'b1;
        ent_waddr = ord_rdata_q;
        st_d      = ST_REPLACED;
        state_d   = S_DONE;
      end
      S_SHRD: begin
        ord_re    = 1'b1;
        ord_raddr = k_q - IdxW'(1);
        state_d   = S_SHWR;
      end
      S_SHWR: begin
        ord_we    = 1'b1;
        ord_waddr = k_q;
        ord_wdata = ord_rdata_q;
        k_d       = k_q - IdxW'(1);
        state_d   = (k_q == IdxW'(1)) ? S_FRONT : S_SHRD;
      end
      S_FRONT: begin
        ord_we    = 1'b1;
        ord_waddr = '0;
        ord_wdata = slot_q;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_mac_d   = res_mac_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- tb/acmf_tb_pkg.sv -----
`timescale 1ns / 1ps

package acmf_tb_pkg;
  import acmf_pkg::*;

  localparam int unsigned SLOT_W = $clog2(ACMF_ENTRIES);

  typedef struct packed {
    status_e          status;
    logic [MAC_W-1:0] mac;
  } reply_t;

  class cache_scoreboard;
    logic [IP_W-1:0]   ip_of[ACMF_ENTRIES];
    logic [MAC_W-1:0]  mac_of[ACMF_ENTRIES];
    logic [SLOT_W-1:0] slot_at[ACMF_ENTRIES];
    int unsigned       used;
    reply_t            expected_replies[$];
    int unsigned       mismatches;
    int unsigned       requests;
    int unsigned       replies;
    int unsigned       status_seen[7];

    function new();
      used       = 0;
      mismatches = 0;
      requests   = 0;
      replies    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int position_of(logic [IP_W-1:0] ip);
      for (int p = 0; p < int'(used); p++) begin
        if (ip_of[slot_at[p]] == ip) return p;
      end
      return -1;
    endfunction

    function void shift_to_front(int unsigned from, logic [SLOT_W-1:0] slot);
      for (int k = from; k > 0; k--) slot_at[k] = slot_at[k-1];
      slot_at[0] = slot;
    endfunction

    function void note_request(cmd_e cmd, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                               logic ins);
      int                pos;
      logic [SLOT_W-1:0] slot;
      reply_t            want;
      pos      = position_of(ip);
      want.mac = '0;
      if (cmd == CMD_LOOKUP) begin
        if (pos >= 0) begin
          slot = slot_at[pos];
          shift_to_front(pos, slot);
          want.mac    = mac_of[slot];
          want.status = ST_HIT;
        end else begin
          want.status = ST_MISS;
        end
      end else if (ip == '0) begin
        want.status = ST_ZERO;
      end else if (pos >= 0) begin
        mac_of[slot_at[pos]] = mac;
        want.status          = ST_UPDATED;
      end else if (!ins) begin
        want.status = ST_SKIPPED;
      end else if (used < ACMF_ENTRIES) begin
        slot         = SLOT_W'(used);
        ip_of[slot]  = ip;
        mac_of[slot] = mac;
        shift_to_front(used, slot);
        used++;
        want.status = ST_INSERTED;
      end else begin
        slot         = slot_at[ACMF_ENTRIES-1];
        ip_of[slot]  = ip;
        mac_of[slot] = mac;
        want.status  = ST_REPLACED;
      end
      requests++;
      status_seen[want.status]++;
      expected_replies.push_back(want);
    endfunction

    function void check_reply(status_e status, logic [MAC_W-1:0] mac);
      reply_t want;
      replies++;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply word, status %0d mac %h", $time, status, mac);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      if (status !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status, status);
        mismatches++;
      end
      if (mac !== want.mac) begin
        $display("%0t: mac_out mismatch, expected %h actual %h", $time, want.mac, mac);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction
  endclass

endpackage

// ----- tb/arp_cache_move_to_front_unit_tb.sv -----
`timescale 1ns / 1ps

module arp_cache_move_to_front_unit_tb;
  import acmf_pkg::*;
  import acmf_tb_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 600;
  localparam int unsigned IP_POOL         = 24;
  localparam int unsigned DRAIN_CYCLES    = 5 * ACMF_ENTRIES + 24;
  localparam int unsigned CYCLE_LIMIT     = 500000;

  logic            clk_i  = 1'b0;
  logic            rst_ni = 1'b0;
  int unsigned     cycles = 0;
  bit              req_burst = 1'b0;
  bit              rsp_burst = 1'b0;
  logic [IP_W-1:0] ip_pool[IP_POOL];
  cache_scoreboard sb = new();

  acmf_req_if req_if ();
  acmf_rsp_if rsp_if ();

  arp_cache_move_to_front_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      sb.note_request(cmd_e'(req_if.cmd), req_if.ip_addr, req_if.mac_in,
                      req_if.insert_allowed);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      sb.check_reply(rsp_if.status, rsp_if.mac_out);
    end
  end

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [IP_W-1:0] pick_ip();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 22) return $urandom;
    return ip_pool[$urandom_range(0, IP_POOL - 1)];
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac();
    int unsigned roll;
    logic [63:0] raw;
    roll = $urandom_range(0, 99);
    raw  = {$urandom, $urandom};
    if (roll < 5) return '1;
    if (roll < 10) return '0;
    return raw[MAC_W-1:0];
  endfunction

  task automatic send_request(cmd_e cmd, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                              logic ins);
    int unsigned gap;
    gap = draw_gap(req_burst);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.cmd            <= cmd;
    req_if.ip_addr        <= ip;
    req_if.mac_in         <= mac;
    req_if.insert_allowed <= ins;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic wait_for_replies();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) rsp_burst = ($urandom_range(0, 2) == 0);
      gap = draw_gap(rsp_burst);
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  initial begin
    req_if.valid          <= 1'b0;
    req_if.cmd            <= CMD_LOOKUP;
    req_if.ip_addr        <= '0;
    req_if.mac_in         <= '0;
    req_if.insert_allowed <= 1'b0;
    foreach (ip_pool[i]) begin
      ip_pool[i] = $urandom;
      if (ip_pool[i] == '0) ip_pool[i] = 32'h0000_0001;
    end
    ip_pool[0] = '1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(CMD_LOOKUP, 32'h0000_0000, 48'h0,              1'b1);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0,              1'b0);
    send_request(CMD_PUT,    32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_request(CMD_PUT,    32'hFFFF_FFFF, 48'h1234_5678_9ABC, 1'b0);
    send_request(CMD_PUT,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_request(CMD_PUT,    32'h0000_0001, 48'h0000_0000_0000, 1'b1);
    send_request(CMD_PUT,    32'h8000_0000, 48'h8000_0000_0000, 1'b1);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0,              1'b0);
    send_request(CMD_LOOKUP, 32'h0000_0001, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_request(CMD_PUT,    32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0);
    send_request(CMD_PUT,    32'h0000_0001, 48'h5555_5555_5555, 1'b1);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0,              1'b1);
    send_request(CMD_LOOKUP, 32'h0000_0000, 48'h0,              1'b0);
    send_request(CMD_PUT,    32'h0000_0000, 48'hAAAA_AAAA_AAAA, 1'b0);
    send_request(CMD_LOOKUP, 32'h8000_0000, 48'h0,              1'b1);
    send_request(CMD_LOOKUP, 32'h7FFF_FFFF, 48'h0,              1'b1);
    wait_for_replies();

    for (int n = 0; n < int'(RANDOM_REQUESTS); n++) begin
      if ($urandom_range(0, 29) == 0) req_burst = ($urandom_range(0, 2) == 0);
      if (n == int'(RANDOM_REQUESTS / 2)) wait_for_replies();
      send_request(cmd_e'($urandom_range(0, 1)), pick_ip(), pick_mac(),
                   $urandom_range(0, 4) != 0);
    end
    wait_for_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests and %0d replies, %0d mismatches",
             sb.requests, sb.replies, sb.mismatches);
    $display("Status mix: hit %0d miss %0d zero-ip %0d updated %0d skipped %0d %s %0d %s %0d",
             sb.status_seen[ST_HIT], sb.status_seen[ST_MISS], sb.status_seen[ST_ZERO],
             sb.status_seen[ST_UPDATED], sb.status_seen[ST_SKIPPED], "inserted",
             sb.status_seen[ST_INSERTED], "replaced", sb.status_seen[ST_REPLACED]);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/acmf_pkg.sv
rtl/core/acmf_req_if.sv
rtl/core/acmf_rsp_if.sv
rtl/core/arp_cache_move_to_front_unit.sv
tb/acmf_tb_pkg.sv
tb/arp_cache_move_to_front_unit_tb.sv
